@@ rtl/srt_pkg.sv @@
// srt_pkg: shared types and constants of the sorted record table
// holds the operation and status codes, the fsm state type and the cell links
// no dependencies
package srt_pkg;

    localparam int KEY_W       = 16;
    localparam int GRADE_W     = 8;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 4;
    localparam int COUNT_OUT_W = 5;
    // wide enough for any index or count at the supported depths
    localparam int POS_W       = 8;

    // operation codes of an input item
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_REVERSE = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 4'd0,
        STAT_UPDATED   = 4'd1,
        STAT_KEPT      = 4'd2,
        STAT_FULL      = 4'd3,
        STAT_DELETED   = 4'd4,
        STAT_NOT_FOUND = 4'd5,
        STAT_REVERSED  = 4'd6,
        STAT_READ_OK   = 4'd7,
        STAT_BAD_INDEX = 4'd8
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // broadcast from the top level to every cell during execution
    typedef struct packed {
        logic                en;
        t_kind               kind;
        logic [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]  grade;
        logic                upd;
        logic                rev;
        logic                ge_any;
        logic                eq_any;
        logic                hit;
        logic                full;
    } t_cell_ctl;

    // cell i to cell i+1: contents and the chains counted from the low end
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]  grade;
        logic                lo_ge;
        logic                lo_eq;
        logic                sel;
        logic                hi_ge;
    } t_up_link;

    // cell i to cell i-1: contents and the chains counted from the high end
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]  grade;
        logic                hi_ge;
        logic                hi_eq;
    } t_dn_link;

endpackage

@@ rtl/srt_cell.sv @@
// srt_cell: one storage cell of the record chain
// compares its record with the item key, passes search flags and data to neighbors
// depends on srt_pkg
module srt_cell (
    input  logic                 i_clk,
    input  srt_pkg::t_cell_ctl   i_ctl,
    input  logic                 i_occ,
    input  logic                 i_tail,
    input  srt_pkg::t_up_link    i_up,
    input  srt_pkg::t_dn_link    i_dn,
    output srt_pkg::t_up_link    o_up,
    output srt_pkg::t_dn_link    o_dn,
    output logic                 o_hit
);

    logic [srt_pkg::KEY_W-1:0]   r_key;
    logic [srt_pkg::GRADE_W-1:0] r_grade;
    logic [srt_pkg::KEY_W-1:0]   n_key;
    logic [srt_pkg::GRADE_W-1:0] n_grade;

    logic ge;
    logic eq;
    logic first_lo;
    logic first_hi;
    logic sel;
    logic shift_up;
    logic shift_down;
    logic load;

    // local compare and search chains
    always_comb begin
        ge       = i_occ && (r_key >= i_ctl.key);
        eq       = i_occ && (r_key == i_ctl.key);
        first_lo = ge && !i_up.lo_ge;
        first_hi = ge && !i_dn.hi_ge;
        sel      = i_ctl.rev ? first_hi : first_lo;
    end

    // links to the neighbors
    always_comb begin
        o_up.key   = r_key;
        o_up.grade = r_grade;
        o_up.lo_ge = ge || i_up.lo_ge;
        o_up.lo_eq = eq || i_up.lo_eq;
        o_up.sel   = sel;
        o_up.hi_ge = ge || i_dn.hi_ge;
        o_dn.key   = r_key;
        o_dn.grade = r_grade;
        o_dn.hi_ge = ge || i_dn.hi_ge;
        o_dn.hi_eq = eq || i_dn.hi_eq;
        o_hit      = sel && eq;
    end

    // move decisions: in reversed order the head sits at the high end
    always_comb begin
        if (i_ctl.rev) begin
            shift_up   = !i_up.hi_ge;
            load       = i_up.sel;
            shift_down = i_ctl.eq_any && !i_dn.hi_eq;
        end else begin
            shift_up   = i_up.lo_ge;
            load       = sel || (i_tail && !i_ctl.ge_any);
            shift_down = eq || i_up.lo_eq;
        end
    end

    // next contents
    always_comb begin
        n_key   = r_key;
        n_grade = r_grade;
        if (i_ctl.en) begin
            unique case (i_ctl.kind)
                srt_pkg::KIND_INSERT: begin
                    if (i_ctl.hit) begin
                        if (i_ctl.upd && sel && eq) begin
                            n_grade = i_ctl.grade;
                        end
                    end else if (!i_ctl.full) begin
                        if (shift_up) begin
                            n_key   = i_up.key;
                            n_grade = i_up.grade;
                        end else if (load) begin
                            n_key   = i_ctl.key;
                            n_grade = i_ctl.grade;
                        end
                    end
                end
                srt_pkg::KIND_DELETE: begin
                    if (i_ctl.eq_any && shift_down) begin
                        n_key   = i_dn.key;
                        n_grade = i_dn.grade;
                    end
                end
                srt_pkg::KIND_REVERSE, srt_pkg::KIND_READ: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_grade <= n_grade;
    end

endmodule

@@ rtl/sorted_record_table.sv @@
// sorted_record_table: ordered table of key and grade records in a chain of cells
// top level: handshake, command register, count, order flag and result register
// depends on srt_pkg and srt_cell
//
// usage: one input channel (i_in_valid / o_in_stall) carries an operation item:
// insert, delete by key, reverse or read at an index. one output channel
// (o_out_valid / i_out_stall) returns one result item per input item with
// status, entry count after the operation and, for a read, the entry.
// an item is taken when valid is high and stall is low at a clock edge.
// the item is registered on acceptance and executed in the next cycle, when
// all cells compare against the key at once and shift one place; the result
// is valid in the cycle after that. the input stalls while an item executes,
// so no new item is taken before it has executed. reverse only flips an order flag.
// when the receiver stalls, the result register holds its item and the input
// side stalls until that result is taken. reset (synchronous, active low)
// empties the table and clears the order flag; no clearing pass is needed.
module sorted_record_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic [srt_pkg::KEY_W-1:0]          i_key,
    input  logic [srt_pkg::GRADE_W-1:0]        i_grade,
    input  logic                               i_update_if_exists,
    input  logic [srt_pkg::INDEX_W-1:0]        i_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [srt_pkg::STATUS_W-1:0]       o_status,
    output logic [srt_pkg::COUNT_OUT_W-1:0]    o_count,
    output logic [srt_pkg::KEY_W-1:0]          o_entry_key,
    output logic [srt_pkg::GRADE_W-1:0]        o_entry_grade
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    srt_pkg::t_state                  r_state;
    srt_pkg::t_state                  n_state;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_rev;
    logic                             n_rev;
    logic                             r_out_valid;

    // command register
    srt_pkg::t_kind                   r_kind;
    logic [srt_pkg::KEY_W-1:0]        r_key;
    logic [srt_pkg::GRADE_W-1:0]      r_grade;
    logic                             r_upd;
    logic [srt_pkg::INDEX_W-1:0]      r_index;

    // result register
    srt_pkg::t_status                 r_status;
    srt_pkg::t_status                 n_status;
    logic [srt_pkg::COUNT_OUT_W-1:0]  r_count_out;
    logic [srt_pkg::KEY_W-1:0]        r_entry_key;
    logic [srt_pkg::KEY_W-1:0]        n_entry_key;
    logic [srt_pkg::GRADE_W-1:0]      r_entry_grade;
    logic [srt_pkg::GRADE_W-1:0]      n_entry_grade;

    logic                             in_acc;
    logic                             out_acc;
    logic                             exec;
    logic                             full;
    logic                             hit;
    logic [31:0]                      count_ext;
    logic [srt_pkg::POS_W-1:0]        idx_ext;
    logic [srt_pkg::POS_W-1:0]        cnt_ext;
    logic [srt_pkg::POS_W-1:0]        phys;
    logic                             rd_ok;

    srt_pkg::t_cell_ctl               ctl;
    srt_pkg::t_up_link                up_base;
    srt_pkg::t_up_link                up_w  [TABLE_DEPTH];
    srt_pkg::t_dn_link                dn_w  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]           hit_w;

    // handshake
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE: if (in_acc) n_state = srt_pkg::S_EXEC;
            srt_pkg::S_EXEC: n_state = srt_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        exec       = (r_state == srt_pkg::S_EXEC);
        o_in_stall = exec || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= srt_pkg::t_kind'(i_kind);
            r_key   <= i_key;
            r_grade <= i_grade;
            r_upd   <= i_update_if_exists;
            r_index <= i_index;
        end
    end

    // broadcast to the cells
    assign full    = (r_count == CNT_W'(TABLE_DEPTH));
    assign hit     = |hit_w;

    always_comb begin
        ctl.en     = exec;
        ctl.kind   = r_kind;
        ctl.key    = r_key;
        ctl.grade  = r_grade;
        ctl.upd    = r_upd;
        ctl.rev    = r_rev;
        ctl.ge_any = up_w[TABLE_DEPTH-1].lo_ge;
        ctl.eq_any = up_w[TABLE_DEPTH-1].lo_eq;
        ctl.hit    = hit;
        ctl.full   = full;
    end

    // virtual neighbor below cell 0: selected when no key is at or above the item key
    always_comb begin
        up_base.key   = '0;
        up_base.grade = '0;
        up_base.lo_ge = 1'b0;
        up_base.lo_eq = 1'b0;
        up_base.sel   = !ctl.ge_any;
        up_base.hi_ge = 1'b1;
    end

    // chain of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        srt_pkg::t_up_link up_in;
        srt_pkg::t_dn_link dn_in;

        if (g == 0) begin : g_first
            assign up_in = up_base;
        end else begin : g_mid
            assign up_in = up_w[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign dn_in = '0;
        end else begin : g_inner
            assign dn_in = dn_w[g+1];
        end

        srt_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_occ  (CNT_W'(g) < r_count),
            .i_tail (CNT_W'(g) == r_count),
            .i_up   (up_in),
            .i_dn   (dn_in),
            .o_up   (up_w[g]),
            .o_dn   (dn_w[g]),
            .o_hit  (hit_w[g])
        );
    end

    // read position: logical index mapped to a cell through the order flag
    always_comb begin
        idx_ext = srt_pkg::POS_W'(r_index);
        cnt_ext = srt_pkg::POS_W'(r_count);
        rd_ok   = idx_ext < cnt_ext;
        phys    = r_rev ? (cnt_ext - 1'b1 - idx_ext) : idx_ext;
    end

    // result of the executing item
    always_comb begin
        n_status      = srt_pkg::STAT_READ_OK;
        n_count       = r_count;
        n_rev         = r_rev;
        n_entry_key   = '0;
        n_entry_grade = '0;
        unique case (r_kind)
            srt_pkg::KIND_INSERT: begin
                if (hit) begin
                    n_status = r_upd ? srt_pkg::STAT_UPDATED : srt_pkg::STAT_KEPT;
                end else if (full) begin
                    n_status = srt_pkg::STAT_FULL;
                end else begin
                    n_status = srt_pkg::STAT_INSERTED;
                    n_count  = r_count + 1'b1;
                end
            end
            srt_pkg::KIND_DELETE: begin
                if (ctl.eq_any) begin
                    n_status = srt_pkg::STAT_DELETED;
                    n_count  = r_count - 1'b1;
                end else begin
                    n_status = srt_pkg::STAT_NOT_FOUND;
                end
            end
            srt_pkg::KIND_REVERSE: begin
                n_status = srt_pkg::STAT_REVERSED;
                n_rev    = !r_rev;
            end
            srt_pkg::KIND_READ: begin
                if (rd_ok) begin
                    n_status = srt_pkg::STAT_READ_OK;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (phys == srt_pkg::POS_W'(i)) begin
                            n_entry_key   = n_entry_key | up_w[i].key;
                            n_entry_grade = n_entry_grade | up_w[i].grade;
                        end
                    end
                end else begin
                    n_status = srt_pkg::STAT_BAD_INDEX;
                end
            end
        endcase
    end

    assign count_ext = 32'(n_count);

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (exec) begin
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status      <= n_status;
            r_count_out   <= count_ext[srt_pkg::COUNT_OUT_W-1:0];
            r_entry_key   <= n_entry_key;
            r_entry_grade <= n_entry_grade;
        end
    end

    assign o_status      = r_status;
    assign o_count       = r_count_out;
    assign o_entry_key   = r_entry_key;
    assign o_entry_grade = r_entry_grade;

    // execution only starts with an empty result register
    a_exec_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> !r_out_valid)
        else $error("execute cycle with a pending result");

    // an accepted item executes in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> exec)
        else $error("accepted item did not execute");

    // the table never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond depth");

    // reverse and read leave the count alone
    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (r_kind == srt_pkg::KIND_REVERSE || r_kind == srt_pkg::KIND_READ))
        |=> (r_count == $past(r_count)))
        else $error("count changed by reverse or read");

endmodule
